>>> rtl/core/dimmer_key_fade_bargraph_core_macros.svh
// Assertion macros shared by the dimmer key/fade/bar graph RTL.
// Needs a clock and an active-low reset name at the point of use.
`ifndef DIMMER_KEY_FADE_BARGRAPH_CORE_MACROS_SVH
`define DIMMER_KEY_FADE_BARGRAPH_CORE_MACROS_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define DKFB_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("dkfb assertion failed");
// checked on every edge, reset included
`define DKFB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dkfb invariant failed");
`else
`define DKFB_ASSERT(lbl, clk, rstn, prop)
`define DKFB_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> rtl/core/dkfb_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the dimmer key/fade/bar graph core.
// No dependencies.
package dkfb_pkg;

    localparam int LVL_W   = 7;
    localparam int LVL_N   = 8;
    localparam int LVLS_W  = LVL_W * LVL_N;
    localparam int HOLD_W  = 8;
    localparam int BAR_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int IN_W    = 8;
    localparam int OUT_W   = 40;

    localparam logic [LVL_W-1:0] LEVEL_FULL = 7'd100;
    localparam logic [LVL_W-1:0] LEVEL_ONE  = 7'd1;
    localparam logic [LVL_W-1:0] PHASE_RST  = 7'd99;

    // bar graph upper bounds for 1..6 LEDs
    localparam logic [LVL_W-1:0] BAR_T1 = 7'd5;
    localparam logic [LVL_W-1:0] BAR_T2 = 7'd20;
    localparam logic [LVL_W-1:0] BAR_T3 = 7'd35;
    localparam logic [LVL_W-1:0] BAR_T4 = 7'd50;
    localparam logic [LVL_W-1:0] BAR_T5 = 7'd65;
    localparam logic [LVL_W-1:0] BAR_T6 = 7'd80;

    localparam logic [1:0] ON_SHORT  = 2'd1;
    localparam logic [1:0] ON_DOUBLE = 2'd2;

    localparam logic [2:0] DIM_PLUS_SHORT  = 3'd1;
    localparam logic [2:0] DIM_PLUS_HELD   = 3'd2;
    localparam logic [2:0] DIM_MINUS_SHORT = 3'd3;
    localparam logic [2:0] DIM_MINUS_HELD  = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_LEVELS,
        CFG_HOLD_REPEAT,
        CFG_MIN_BRIGHT
    } t_cfg_idx;

    typedef struct packed {
        logic [LVLS_W-1:0] step_levels;
        logic [HOLD_W-1:0] hold_repeat_ticks;
        logic [LVL_W-1:0]  min_brightness;
    } t_cfg;

    // LSB first: power_on_key, power_off_key, dim_key, learn_mode, wifi_test
    typedef struct packed {
        logic       wifi_test;
        logic       learn_mode;
        logic [2:0] dim_key;
        logic       power_off_key;
        logic [1:0] power_on_key;
    } t_in_item;

    typedef struct packed {
        logic             sync_request;
        logic [1:0]       power_reports;
        logic             relay_state;
        logic             lamp_on;
        logic [LVL_W-1:0] bar_leds;
        logic [LVL_W-1:0] phase_delay;
        logic [LVL_W-1:0] fade_level;
        logic [LVL_W-1:0] brightness;
    } t_result;

    typedef struct packed {
        logic              power;
        logic              off_pending;
        logic [LVL_W-1:0]  target;
        logic [LVL_W-1:0]  faded;
        logic              fading;
        logic [BAR_W-1:0]  bar_cnt;
        logic [HOLD_W-1:0] hold;
        logic              relay;
        logic [LVL_W-1:0]  phase;
    } t_state;

    localparam t_state STATE_RST = '{
        power:       1'b0,
        off_pending: 1'b0,
        target:      LEVEL_FULL,
        faded:       LEVEL_ONE,
        fading:      1'b0,
        bar_cnt:     '0,
        hold:        '0,
        relay:       1'b0,
        phase:       PHASE_RST
    };

    function automatic logic [LVL_W-1:0] level_at(input logic [LVLS_W-1:0] levels,
                                                  input logic [2:0] k);
        level_at = levels[LVL_W * int'(k) +: LVL_W];
    endfunction

endpackage

>>> rtl/core/dkfb_cfg.sv
`timescale 1ns / 1ps
// Configuration register file: level table, hold repeat interval, brightness floor.
// Depends on dkfb_pkg.
module dkfb_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dkfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dkfb_pkg::LVLS_W-1:0]    i_cfg_data,
    output dkfb_pkg::t_cfg                o_cfg
);

    logic [dkfb_pkg::LVLS_W-1:0] r_step_levels;
    logic [dkfb_pkg::HOLD_W-1:0] r_hold_repeat;
    logic [dkfb_pkg::LVL_W-1:0]  r_min_bright;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_levels <= '0;
            r_hold_repeat <= 8'd10;
            r_min_bright  <= 7'd1;
        end else if (i_cfg_valid) begin
            unique case (dkfb_pkg::t_cfg_idx'(i_cfg_index))
                dkfb_pkg::CFG_STEP_LEVELS: r_step_levels <= i_cfg_data;
                dkfb_pkg::CFG_HOLD_REPEAT: r_hold_repeat <= i_cfg_data[dkfb_pkg::HOLD_W-1:0];
                dkfb_pkg::CFG_MIN_BRIGHT:  r_min_bright  <= i_cfg_data[dkfb_pkg::LVL_W-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    assign o_cfg = '{
        step_levels:       r_step_levels,
        hold_repeat_ticks: r_hold_repeat,
        min_brightness:    r_min_bright
    };

endmodule

>>> rtl/core/dkfb_step.sv
`timescale 1ns / 1ps
// One control tick: key handling, fade step, phase value and bar graph.
// Pure next-state/result logic. Depends on dkfb_pkg.
module dkfb_step (
    input  dkfb_pkg::t_cfg     i_cfg,
    input  dkfb_pkg::t_state   i_state,
    input  dkfb_pkg::t_in_item i_item,
    output dkfb_pkg::t_state   o_next_state,
    output dkfb_pkg::t_result  o_result
);

    logic [dkfb_pkg::LVL_W-1:0] up_pick;
    logic [dkfb_pkg::LVL_W-1:0] down_pick;
    logic [dkfb_pkg::LVL_W-1:0] prev;
    logic [dkfb_pkg::LVL_W-1:0] goal;
    logic [dkfb_pkg::HOLD_W-1:0] hold_inc;
    logic [1:0] reports;
    logic       sync;
    logic       dim_act;
    logic [7:0] bar_mask;
    dkfb_pkg::t_state st;

    // target after power keys; needed for the table picks
    always_comb begin
        prev = i_state.target;
        if (i_item.power_on_key != dkfb_pkg::ON_SHORT && !i_item.power_off_key
            && i_item.power_on_key == dkfb_pkg::ON_DOUBLE && !i_state.off_pending) begin
            prev = dkfb_pkg::LEVEL_FULL;
        end else if (i_item.power_on_key != dkfb_pkg::ON_SHORT && !i_item.power_off_key
            && i_item.power_on_key == dkfb_pkg::ON_DOUBLE && i_state.power) begin
            prev = dkfb_pkg::LEVEL_FULL;
        end
    end

    // first level above the target, else the top level
    always_comb begin
        up_pick = dkfb_pkg::level_at(i_cfg.step_levels, 3'd7);
        for (int k = dkfb_pkg::LVL_N - 1; k >= 0; k--) begin
            if (prev < dkfb_pkg::level_at(i_cfg.step_levels, 3'(k))) begin
                up_pick = dkfb_pkg::level_at(i_cfg.step_levels, 3'(k));
            end
        end
    end

    // highest of levels 0..6 below the target, else level 0
    always_comb begin
        down_pick = dkfb_pkg::level_at(i_cfg.step_levels, 3'd0);
        for (int k = 0; k < dkfb_pkg::LVL_N - 1; k++) begin
            if (prev > dkfb_pkg::level_at(i_cfg.step_levels, 3'(k))) begin
                down_pick = dkfb_pkg::level_at(i_cfg.step_levels, 3'(k));
            end
        end
    end

    always_comb begin
        st       = i_state;
        reports  = 2'd0;
        sync     = 1'b0;
        hold_inc = i_state.hold + 8'd1;
        dim_act  = (i_item.dim_key >= dkfb_pkg::DIM_PLUS_SHORT)
                && (i_item.dim_key <= dkfb_pkg::DIM_MINUS_HELD) && !i_item.learn_mode;

        // power keys, on-short first
        priority if (i_item.power_on_key == dkfb_pkg::ON_SHORT) begin
            if (!st.power && !st.off_pending) begin
                st.power = 1'b1;
                reports  = reports + 2'd1;
                st.relay = ~st.relay;
            end
        end else if (i_item.power_off_key) begin
            if (st.power) begin
                st.power       = 1'b0;
                reports        = reports + 2'd1;
                st.off_pending = 1'b1;
            end
        end else if (i_item.power_on_key == dkfb_pkg::ON_DOUBLE) begin
            if (!st.power && !st.off_pending) begin
                st.power  = 1'b1;
                reports   = reports + 2'd1;
                st.relay  = ~st.relay;
                st.target = dkfb_pkg::LEVEL_FULL;
            end else if (st.power) begin
                st.target = dkfb_pkg::LEVEL_FULL;
            end
        end else begin
        end

        // dim keys
        if (dim_act) begin
            if (!st.power) begin
                st.power = 1'b1;
                reports  = reports + 2'd1;
                st.relay = ~st.relay;
            end
            priority if (i_item.dim_key == dkfb_pkg::DIM_PLUS_SHORT) begin
                st.target = up_pick;
            end else if (i_item.dim_key == dkfb_pkg::DIM_MINUS_SHORT) begin
                st.target = down_pick;
            end else begin
                st.hold = hold_inc;
                if (hold_inc >= i_cfg.hold_repeat_ticks) begin
                    st.hold = '0;
                    if (i_item.dim_key == dkfb_pkg::DIM_PLUS_HELD) begin
                        if (st.target < dkfb_pkg::LEVEL_FULL) st.target = st.target + 7'd1;
                    end else begin
                        if (st.target > dkfb_pkg::LEVEL_ONE) st.target = st.target - 7'd1;
                    end
                end
            end
            if (st.target <= i_cfg.min_brightness) st.target = i_cfg.min_brightness;
            sync = (st.target != prev);
        end else begin
            st.hold = '0;
        end

        // fade one step toward the goal
        if (st.target > dkfb_pkg::LEVEL_FULL) st.target = dkfb_pkg::LEVEL_FULL;
        if (st.power) begin
            goal      = st.target;
            st.fading = 1'b1;
        end else begin
            goal = dkfb_pkg::LEVEL_ONE;
        end
        if (st.faded < goal) st.faded = st.faded + 7'd1;
        else if (st.faded > goal) st.faded = st.faded - 7'd1;
        if (st.faded <= dkfb_pkg::LEVEL_ONE) begin
            st.fading = 1'b0;
            if (st.off_pending) begin
                st.relay       = ~st.relay;
                st.off_pending = 1'b0;
            end
        end
        // phase register holds while the fade sits at zero
        if (st.faded >= dkfb_pkg::LEVEL_ONE && st.faded <= dkfb_pkg::LEVEL_FULL) begin
            st.phase = dkfb_pkg::LEVEL_FULL - st.faded;
        end

        // bar graph
        if (st.power || st.fading) begin
            priority if (st.faded <= dkfb_pkg::BAR_T1) st.bar_cnt = 3'd1;
            else if (st.faded <= dkfb_pkg::BAR_T2)     st.bar_cnt = 3'd2;
            else if (st.faded <= dkfb_pkg::BAR_T3)     st.bar_cnt = 3'd3;
            else if (st.faded <= dkfb_pkg::BAR_T4)     st.bar_cnt = 3'd4;
            else if (st.faded <= dkfb_pkg::BAR_T5)     st.bar_cnt = 3'd5;
            else if (st.faded <= dkfb_pkg::BAR_T6)     st.bar_cnt = 3'd6;
            else                                       st.bar_cnt = 3'd7;
        end else if (!i_item.wifi_test) begin
            st.bar_cnt = '0;
        end

        bar_mask = (8'd1 << st.bar_cnt) - 8'd1;
    end

    assign o_next_state = st;

    assign o_result = '{
        sync_request:  sync,
        power_reports: reports,
        relay_state:   st.relay,
        lamp_on:       st.power,
        bar_leds:      bar_mask[dkfb_pkg::LVL_W-1:0],
        phase_delay:   st.phase,
        fade_level:    st.faded,
        brightness:    st.target
    };

endmodule

>>> rtl/core/dimmer_key_fade_bargraph_core.sv
`timescale 1ns / 1ps
// Dimmer key/fade/bar graph core: top level with word registers and state.
// Depends on dkfb_pkg, dkfb_cfg, dkfb_step and the macros header.
//
// Usage:
//   s_axis carries one control tick per word (decoded key events and mode bits);
//   m_axis returns exactly one result word per tick, in order.
//   The cfg channel (i_cfg_valid/o_cfg_ready, index, data) writes the level
//   table (0), hold repeat interval (1) and brightness floor (2); it is always
//   ready and is to be used only while no tick is in flight.
// Path: a tick accepted into the input register is processed by the step logic
//   and lands in the result register when that register is free or draining.
// Throughput: one tick per cycle while m_axis_tready stays high; the state loop
//   through dkfb_step is combinational, so back-to-back ticks need no bubbles.
// Stall: while m_axis_tready is low the result word holds and the state
//   freezes; one more tick is taken into the input register, then s_axis_tready
//   drops until the result word is taken.
// Reset (i_rst_n low at an edge): lamp off, relay off, target 100, fade 1,
//   phase 99, bar dark, config back to defaults, both word registers empty.
`include "dimmer_key_fade_bargraph_core_macros.svh"

module dimmer_key_fade_bargraph_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dkfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dkfb_pkg::LVLS_W-1:0]    i_cfg_data,
    // tick input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [1:0] power_on_key, [2] power_off_key, [5:3] dim_key, [6] learn_mode,
    // [7] wifi_test
    input  logic [dkfb_pkg::IN_W-1:0]      s_axis_tdata,
    // result output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [6:0] brightness, [13:7] fade_level, [20:14] phase_delay, [27:21] bar_leds,
    // [28] lamp_on, [29] relay_state, [31:30] power_reports, [32] sync_request,
    // [39:33] zero
    output logic [dkfb_pkg::OUT_W-1:0]     m_axis_tdata
);

    dkfb_pkg::t_cfg      cfg;
    dkfb_pkg::t_in_item  r_in;
    logic                r_in_valid;
    dkfb_pkg::t_state    r_state;
    dkfb_pkg::t_state    n_state;
    dkfb_pkg::t_result   r_out;
    dkfb_pkg::t_result   n_out;
    logic                r_out_valid;
    logic                advance;

    dkfb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    dkfb_step u_step (
        .i_cfg        (cfg),
        .i_state      (r_state),
        .i_item       (r_in),
        .o_next_state (n_state),
        .o_result     (n_out)
    );

    // tick moves into the result register when that register is free or draining
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= dkfb_pkg::STATE_RST;
        end else begin
            if (s_axis_tvalid && s_axis_tready) r_in_valid <= 1'b1;
            else if (advance)                  r_in_valid <= 1'b0;

            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_in <= dkfb_pkg::t_in_item'(s_axis_tdata);
        if (advance) r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = dkfb_pkg::OUT_W'(r_out);

    `DKFB_ASSERT_ALWAYS(a_target_in_range, i_clk,
        !i_rst_n || r_state.target <= dkfb_pkg::LEVEL_FULL)
    `DKFB_ASSERT(a_phase_matches_fade, i_clk, i_rst_n,
        r_out_valid && r_out.fade_level != 7'd0
        |-> 8'(r_out.phase_delay) + 8'(r_out.fade_level) == 8'd100)
    `DKFB_ASSERT(a_sync_implies_on, i_clk, i_rst_n, r_out_valid && r_out.sync_request |-> r_out.lamp_on)
    `DKFB_ASSERT(a_stall_freezes_state, i_clk, i_rst_n,
        r_out_valid && !m_axis_tready |=> $stable(r_state))

endmodule
